>>> sv/rational_arithmetic_unit_top_macros.svh
// ----------------------------------------------------------------------------
// Rational arithmetic unit assertion macros
// Assertion macros used by the block's RTL file.
// ----------------------------------------------------------------------------
`ifndef RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH
`define RATIONAL_ARITHMETIC_UNIT_TOP_MACROS_SVH

// Same-cycle implication, disabled while the active-low reset is low.
`define RAU_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while the active-low reset is low.
`define RAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> sv/rau_pkg.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Word types, operation and status codes, and sequencer states.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_DIV0 = 2'd1;
    localparam logic [1:0] STATUS_OVF  = 2'd2;

    typedef struct packed {
        logic [1:0]         op;
        logic signed [31:0] a_num;
        logic [30:0]        a_den;
        logic signed [31:0] b_num;
        logic [30:0]        b_den;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] result_num;
        logic [30:0]        result_den;
        logic [1:0]         status;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM,
        ST_ABS,
        ST_GCD,
        ST_SHIFT,
        ST_DIV_NUM,
        ST_DIV_DEN,
        ST_CHECK,
        ST_OUT
    } t_state;

endpackage

>>> sv/rational_arithmetic_unit_top.sv
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Adds, subtracts, multiplies or divides two fractions and reduces the result.
// ----------------------------------------------------------------------------
// One word is taken at a time and the input stalls until its result has been
// taken. A word runs three products on the shared 33 by 33 multiplier, a
// binary gcd loop of shifts and subtracts that runs a data-dependent number
// of steps, and two 64-step restoring divisions on the same subtractor. A
// zero numerator skips the gcd and the divisions, and operand errors return
// at once.
`include "rational_arithmetic_unit_top_macros.svh"

module rational_arithmetic_unit_top
    import rau_pkg::*;
#(
    parameter int WORD_BITS = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_word
);

    localparam logic [63:0] LIM = (64'd1 << (WORD_BITS - 1)) - 64'd1;

    t_state             r_state, n_state;
    t_in_word           r_in;
    t_out_word          r_out;
    logic signed [63:0] r_p1, r_p2;
    logic [63:0]        r_den, r_mag, r_x, r_y, r_d, r_rem;
    logic               r_neg;
    logic [5:0]         r_k, r_cnt;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        sub_a, sub_b;
    logic [64:0]        sub_d;
    logic [63:0]        trial;
    logic               in_err, accept;
    logic signed [32:0] an_x, bn_x, ad_x, bd_x;
    logic signed [63:0] sum;

    assign accept = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);
    assign o_out_valid = (r_state == ST_OUT);
    assign o_out_word = r_out;

    assign in_err = (i_in_word.a_den == '0) || (i_in_word.b_den == '0) ||
                    (i_in_word.op == OP_DIV && i_in_word.b_num == '0);

    assign an_x = {r_in.a_num[31], r_in.a_num};
    assign bn_x = {r_in.b_num[31], r_in.b_num};
    assign ad_x = {2'b00, r_in.a_den};
    assign bd_x = {2'b00, r_in.b_den};

    always_comb begin
        mul_a = an_x;
        mul_b = bd_x;
        case (r_state)
            ST_MUL1: begin
                mul_a = an_x;
                if (r_in.op == OP_MUL) begin
                    mul_b = bn_x;
                end else if (r_in.op == OP_DIV && r_in.b_num[31]) begin
                    mul_b = -bd_x;
                end else begin
                    mul_b = bd_x;
                end
            end
            ST_MUL2: begin
                mul_a = ad_x;
                mul_b = bn_x;
            end
            ST_MUL3: begin
                mul_a = ad_x;
                if (r_in.op == OP_DIV) begin
                    mul_b = r_in.b_num[31] ? -bn_x : bn_x;
                end else begin
                    mul_b = bd_x;
                end
            end
            default: begin
                mul_a = an_x;
                mul_b = bd_x;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;
    assign sum = (r_in.op == OP_SUB) ? (r_p1 - r_p2) : (r_p1 + r_p2);
    assign trial = {r_rem[62:0], r_d[63]};

    always_comb begin
        if (r_state == ST_GCD) begin
            sub_a = r_x;
            sub_b = r_y;
        end else begin
            sub_a = trial;
            sub_b = r_x;
        end
    end

    assign sub_d = {1'b0, sub_a} - {1'b0, sub_b};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = in_err ? ST_OUT : ST_MUL1;
                end
            end
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_MUL3;
            ST_MUL3:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_ABS;
            ST_ABS:   n_state = (r_p1 == '0) ? ST_CHECK : ST_GCD;
            ST_GCD: begin
                if (sub_d == '0) begin
                    n_state = ST_SHIFT;
                end
            end
            ST_SHIFT: n_state = ST_DIV_NUM;
            ST_DIV_NUM: begin
                if (r_cnt == 6'd63) begin
                    n_state = ST_DIV_DEN;
                end
            end
            ST_DIV_DEN: begin
                if (r_cnt == 6'd63) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: n_state = ST_OUT;
            ST_OUT: begin
                if (!i_out_stall) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_in <= i_in_word;
                r_out.result_num <= '0;
                r_out.result_den <= 31'd1;
                r_out.status <= in_err ? STATUS_DIV0 : STATUS_OK;
            end
            ST_MUL1: r_p1 <= mul_p[63:0];
            ST_MUL2: begin
                if (r_in.op == OP_ADD || r_in.op == OP_SUB) begin
                    r_p2 <= mul_p[63:0];
                end else begin
                    r_p2 <= '0;
                end
            end
            ST_MUL3: r_den <= mul_p[63:0];
            ST_SUM:  r_p1 <= sum;
            ST_ABS: begin
                r_neg <= r_p1[63];
                r_mag <= r_p1[63] ? 64'(-r_p1) : 64'(r_p1);
                r_x <= r_p1[63] ? 64'(-r_p1) : 64'(r_p1);
                r_y <= r_den;
                r_k <= '0;
                if (r_p1 == '0) begin
                    r_den <= 64'd1;
                end
            end
            ST_GCD: begin
                if (sub_d != '0) begin
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_k <= r_k + 6'd1;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (!sub_d[64]) begin
                        r_x <= sub_d[64:1];
                    end else begin
                        r_y <= 64'(-sub_d) >> 1;
                    end
                end
            end
            ST_SHIFT: begin
                r_d <= r_mag >> r_k;
                r_y <= r_den >> r_k;
                r_rem <= '0;
                r_cnt <= '0;
            end
            ST_DIV_NUM, ST_DIV_DEN: begin
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_rem <= '0;
                    if (r_state == ST_DIV_NUM) begin
                        r_mag <= {r_d[62:0], ~sub_d[64]};
                        r_d <= r_y;
                    end else begin
                        r_den <= {r_d[62:0], ~sub_d[64]};
                    end
                end else begin
                    r_rem <= sub_d[64] ? trial : sub_d[63:0];
                    r_d <= {r_d[62:0], ~sub_d[64]};
                end
            end
            ST_CHECK: begin
                if (r_mag > LIM || r_den > LIM) begin
                    r_out.result_num <= '0;
                    r_out.result_den <= 31'd1;
                    r_out.status <= STATUS_OVF;
                end else begin
                    r_out.result_num <= r_neg ? -r_mag[31:0] : r_mag[31:0];
                    r_out.result_den <= r_den[30:0];
                    r_out.status <= STATUS_OK;
                end
            end
            default: begin
            end
        endcase
    end

    `RAU_ASSERT_IMPL(a_out_blocks_in, i_clk, i_rst_n, o_out_valid, o_in_stall)
    `RAU_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, accept, o_in_stall)
    `RAU_ASSERT_IMPL(a_den_nonzero, i_clk, i_rst_n, o_out_valid, o_out_word.result_den != '0)
    `RAU_ASSERT_IMPL(a_err_zero, i_clk, i_rst_n, o_out_valid && o_out_word.status != STATUS_OK,
        o_out_word.result_num == '0 && o_out_word.result_den == 31'd1)

endmodule
